FILE: sv/evas_pkg.sv
package evas_pkg;

  localparam int SAMPLE_W = 16;
  localparam int ENERGY_W = 48;
  localparam int DSUM_W   = 18;
  localparam int SQ_W     = 31;
  localparam int QDEPTH   = 4;

  localparam logic [ENERGY_W-1:0] E48_MAX = '1;

  // divide by three: floor(m * 43691 / 2^17) is exact for m below 2^17
  localparam logic [15:0] DIV3_RECIP = 16'd43691;
  localparam int          DIV3_SHIFT = 17;

  localparam logic [2:0] CFG_STEREO     = 3'd0;
  localparam logic [2:0] CFG_WINDOW_LEN = 3'd1;
  localparam logic [2:0] CFG_SPEECH_E   = 3'd2;
  localparam logic [2:0] CFG_START_E    = 3'd3;
  localparam logic [2:0] CFG_START_HITS = 3'd4;
  localparam logic [2:0] CFG_END_SIL    = 3'd5;
  localparam logic [2:0] CFG_MAX_WAIT   = 3'd6;

  typedef enum logic [1:0] {
    EV_SAMPLE  = 2'd0,
    EV_START   = 2'd1,
    EV_END     = 2'd2,
    EV_TIMEOUT = 2'd3
  } ev_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
  } in_word_t;

  typedef struct packed {
    ev_t                        event_res;
    logic signed [SAMPLE_W-1:0] audio;
    logic                       last;
  } out_word_t;

  typedef struct packed {
    logic                stereo_mode;
    logic [15:0]         window_len;
    logic [ENERGY_W-1:0] speech_energy;
    logic [ENERGY_W-1:0] start_energy_min;
    logic [7:0]          start_hits;
    logic [15:0]         end_silence_windows;
    logic [15:0]         max_wait_windows;
  } cfg_t;

  // queued result: decimated sum is divided by three on the way out
  typedef struct packed {
    ev_t                      ev;
    logic signed [DSUM_W-1:0] dsum;
    logic                     last;
  } q_entry_t;

  typedef struct packed {
    logic [1:0] n;
    q_entry_t   e0;
    q_entry_t   e1;
  } push_t;

endpackage

FILE: sv/evas_front.sv
module evas_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  evas_pkg::in_word_t                in_data,
  input  logic                              stereo_mode,
  input  logic                              b_adv,
  output logic                              b_valid,
  output logic signed [evas_pkg::SAMPLE_W-1:0] b_mono,
  output logic [evas_pkg::SQ_W-1:0]         b_sq
);
  import evas_pkg::*;

  logic     a_valid;
  in_word_t a_word;
  logic     a_move;
  logic     b_load;

  logic signed [SAMPLE_W:0]     pair_sum;
  logic signed [SAMPLE_W-1:0]   mono;
  logic signed [2*SAMPLE_W-1:0] prod;

  assign b_load   = !b_valid || b_adv;
  assign a_move   = a_valid && b_load;
  assign in_ready = !a_valid || a_move;

  // floor of the pair average
  assign pair_sum = (SAMPLE_W+1)'(a_word.left_sample) + (SAMPLE_W+1)'(a_word.right_sample);
  assign mono     = stereo_mode ? pair_sum[SAMPLE_W:1] : a_word.left_sample;
  assign prod     = mono * mono;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (in_ready) a_valid <= in_valid;
      if (b_load) b_valid <= a_move;
    end
    if (in_valid && in_ready) a_word <= in_data;
    if (a_move) begin
      b_mono <= mono;
      b_sq   <= prod[SQ_W-1:0];
    end
  end

endmodule

FILE: sv/evas_track.sv
module evas_track (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 go,
  input  logic signed [evas_pkg::SAMPLE_W-1:0] mono,
  input  logic [evas_pkg::SQ_W-1:0]            sq,
  input  evas_pkg::cfg_t                       cfg,
  output evas_pkg::push_t                      push
);
  import evas_pkg::*;

  logic                     recording, recording_next;
  logic [7:0]               hit_count, hit_count_next;
  logic [15:0]              quiet_windows, quiet_windows_next;
  logic [16:0]              waited_windows, waited_windows_next;
  logic [15:0]              window_pos, window_pos_next;
  logic [ENERGY_W-1:0]      energy_sum, energy_sum_next;
  logic [1:0]               decim_phase, decim_phase_next;
  logic signed [DSUM_W-1:0] decim_sum, decim_sum_next;

  logic [ENERGY_W:0]        e_add;
  logic [ENERGY_W-1:0]      e_win;
  logic                     close;
  logic signed [DSUM_W-1:0] dsum_add;
  logic [16:0]              waited_inc;
  logic [7:0]               hit_inc;
  logic [15:0]              quiet_new;
  logic                     p_sample, p_ev;
  ev_t                      ev_code;
  logic signed [DSUM_W-1:0] sample_sum;
  q_entry_t                 ent_sample, ent_ev;

  assign e_add      = {1'b0, energy_sum} + (ENERGY_W+1)'(sq);
  assign e_win      = e_add[ENERGY_W] ? E48_MAX : e_add[ENERGY_W-1:0];
  assign close      = ({1'b0, window_pos} + 17'd1) >= {1'b0, cfg.window_len};
  assign dsum_add   = decim_sum + DSUM_W'(mono);
  assign waited_inc = waited_windows + 17'd1;
  assign hit_inc    = (hit_count == 8'hFF) ? hit_count : hit_count + 8'd1;

  always_comb begin
    recording_next      = recording;
    hit_count_next      = hit_count;
    quiet_windows_next  = quiet_windows;
    waited_windows_next = waited_windows;
    window_pos_next     = window_pos + 16'd1;
    energy_sum_next     = e_win;
    decim_phase_next    = decim_phase;
    decim_sum_next      = decim_sum;
    quiet_new           = quiet_windows;
    p_sample            = 1'b0;
    p_ev                = 1'b0;
    ev_code             = EV_SAMPLE;
    sample_sum          = dsum_add;

    if (recording) begin
      if (decim_phase == 2'd2) begin
        p_sample         = 1'b1;
        decim_phase_next = 2'd0;
        decim_sum_next   = '0;
      end else begin
        decim_phase_next = decim_phase + 2'd1;
        decim_sum_next   = dsum_add;
      end
    end

    if (close) begin
      window_pos_next = '0;
      energy_sum_next = '0;
      if (!recording) begin
        waited_windows_next = waited_inc;
        if (waited_inc > {1'b0, cfg.max_wait_windows}) begin
          p_ev    = 1'b1;
          ev_code = EV_TIMEOUT;
        end else if (e_win > cfg.speech_energy && e_win >= cfg.start_energy_min) begin
          hit_count_next = hit_inc;
          if (hit_inc >= cfg.start_hits) begin
            recording_next     = 1'b1;
            quiet_windows_next = '0;
            decim_phase_next   = '0;
            decim_sum_next     = '0;
            p_ev               = 1'b1;
            ev_code            = EV_START;
          end
        end else begin
          hit_count_next = '0;
        end
      end else begin
        if (e_win < cfg.speech_energy) begin
          quiet_new = (quiet_windows == 16'hFFFF) ? quiet_windows : quiet_windows + 16'd1;
        end else begin
          quiet_new = '0;
        end
        quiet_windows_next = quiet_new;
        if (quiet_new >= cfg.end_silence_windows) begin
          p_ev    = 1'b1;
          ev_code = EV_END;
        end
      end
      // timeout and segment end both drop back to waiting
      if (p_ev && (ev_code == EV_TIMEOUT || ev_code == EV_END)) begin
        recording_next      = 1'b0;
        hit_count_next      = '0;
        quiet_windows_next  = '0;
        waited_windows_next = '0;
        decim_phase_next    = '0;
        decim_sum_next      = '0;
      end
    end
  end

  always_comb begin
    ent_sample.ev   = EV_SAMPLE;
    ent_sample.dsum = sample_sum;
    ent_sample.last = !p_ev;
    ent_ev.ev       = ev_code;
    ent_ev.dsum     = '0;
    ent_ev.last     = 1'b1;
    push.n          = {1'b0, p_sample} + {1'b0, p_ev};
    push.e0         = p_sample ? ent_sample : ent_ev;
    push.e1         = ent_ev;
    if (!go) push.n = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recording      <= 1'b0;
      hit_count      <= '0;
      quiet_windows  <= '0;
      waited_windows <= '0;
      window_pos     <= '0;
      energy_sum     <= '0;
      decim_phase    <= '0;
      decim_sum      <= '0;
    end else if (go) begin
      recording      <= recording_next;
      hit_count      <= hit_count_next;
      quiet_windows  <= quiet_windows_next;
      waited_windows <= waited_windows_next;
      window_pos     <= window_pos_next;
      energy_sum     <= energy_sum_next;
      decim_phase    <= decim_phase_next;
      decim_sum      <= decim_sum_next;
    end
  end

endmodule

FILE: sv/evas_outq.sv
module evas_outq (
  input  logic                clk,
  input  logic                rst,
  input  evas_pkg::push_t     push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output evas_pkg::out_word_t out_data
);
  import evas_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  q_entry_t      q [QDEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;
  logic          pop;

  q_entry_t          head;
  logic              neg;
  logic [DSUM_W-1:0] mag;
  logic [32:0]       quot_prod;
  logic [15:0]       quot;

  assign room      = count <= (PW+1)'(QDEPTH - 2);
  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;

  // head sum divided by three, truncated toward zero
  assign head      = q[rd_ptr];
  assign neg       = head.dsum[DSUM_W-1];
  assign mag       = neg ? DSUM_W'(-head.dsum) : DSUM_W'(head.dsum);
  assign quot_prod = mag[16:0] * DIV3_RECIP;
  assign quot      = quot_prod[DIV3_SHIFT +: 16];

  always_comb begin
    out_data.event_res = head.ev;
    out_data.audio     = neg ? SAMPLE_W'(-quot) : SAMPLE_W'(quot);
    out_data.last      = head.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.n);
      rd_ptr <= rd_ptr + PW'(pop);
      count  <= count + (PW+1)'(push.n) - (PW+1)'(pop);
    end
    if (push.n != 2'd0) q[wr_ptr] <= push.e0;
    if (push.n == 2'd2) q[wr_ptr + PW'(1)] <= push.e1;
  end

endmodule

FILE: sv/energy_voice_activity_segmenter_core.sv
// energy based voice activity segmenter
// in channel: one stereo audio word per handshake (in_valid / in_ready),
// q1.15 left and right; in mono mode the right sample is ignored
// out channel: result words (out_valid / out_ready): decimated samples while
// recording, and start, segment end and timeout events; last marks the final
// result word caused by one input word, and a word may cause none
// config: cfg_we writes cfg_data into register cfg_index at the clock edge;
// writing only while the block is idle is up to the user, unchecked; index 7 is ignored
// timing: an input stage, a mono and square stage, then the state update
// that queues results; results are offered only from the queue, after the
// state update has pushed them. one word per cycle is accepted as long as
// the four entry result queue has room for two more entries
// stall: when out_ready stays low the queue fills and in_ready drops;
// no result is lost
// reset (rst, synchronous): all counters, window sum and decimator cleared,
// waiting for speech, queue empty, registers at their defaults
module energy_voice_activity_segmenter_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  evas_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output evas_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [47:0]         cfg_data
);
  import evas_pkg::*;

  cfg_t cfg;

  // mono / square stage handoff
  logic                       b_valid;
  logic                       b_adv;
  logic signed [SAMPLE_W-1:0] b_mono;
  logic [SQ_W-1:0]            b_sq;

  // queue handoff
  push_t push;
  logic  room;

  // register file; writing only while idle is up to the user, unchecked
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stereo_mode         <= 1'b1;
      cfg.window_len          <= 16'd1440;
      cfg.speech_energy       <= 48'd1000000000;
      cfg.start_energy_min    <= 48'd1000000000;
      cfg.start_hits          <= 8'd3;
      cfg.end_silence_windows <= 16'd27;
      cfg.max_wait_windows    <= 16'd333;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEREO:     cfg.stereo_mode         <= cfg_data[0];
        CFG_WINDOW_LEN: cfg.window_len          <= cfg_data[15:0];
        CFG_SPEECH_E:   cfg.speech_energy       <= cfg_data;
        CFG_START_E:    cfg.start_energy_min    <= cfg_data;
        CFG_START_HITS: cfg.start_hits          <= cfg_data[7:0];
        CFG_END_SIL:    cfg.end_silence_windows <= cfg_data[15:0];
        CFG_MAX_WAIT:   cfg.max_wait_windows    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // the state update runs only when the queue can take both possible results
  assign b_adv = b_valid && room;

  evas_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .stereo_mode (cfg.stereo_mode),
    .b_adv       (b_adv),
    .b_valid     (b_valid),
    .b_mono      (b_mono),
    .b_sq        (b_sq)
  );

  evas_track u_track (
    .clk  (clk),
    .rst  (rst),
    .go   (b_adv),
    .mono (b_mono),
    .sq   (b_sq),
    .cfg  (cfg),
    .push (push)
  );

  evas_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  // queue comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result queue not empty after reset");

  // events carry no audio
  a_event_no_audio: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.event_res != EV_SAMPLE) |-> (out_data.audio == '0))
    else $error("event word with nonzero audio");

  // a word with two results always has the decimated sample first
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.last) |-> (out_data.event_res == EV_SAMPLE))
    else $error("non-final result is not a decimated sample");

  // no state update without room for two results
  a_room: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |-> room)
    else $error("results pushed into a full queue");
`endif

endmodule

FILE: dv/tb_energy_voice_activity_segmenter_core.sv
`timescale 1ns / 1ps

// self-checking bench for the energy based voice activity segmenter
// every accepted stereo word is run through a local predictor of the
// segmenter; the result words it predicts are queued and compared in
// order against what the block hands out on the out channel
module tb_energy_voice_activity_segmenter_core;
  import evas_pkg::*;

  // index 7 is outside the register map and must be ignored
  localparam logic [2:0] CFG_UNUSED = 3'd7;

  // cycles to let a word that causes no result finish its way through
  // the pipeline before registers are touched or the run ends
  localparam int DRAIN_CYCLES = 12;

  // receiver hold-off for the backpressure test, in clock cycles
  localparam int LONG_HOLD_CYCLES = 300;

  // word classes for generated audio
  localparam int FRAME_LOUD  = 0;
  localparam int FRAME_QUIET = 1;
  localparam int FRAME_NOISE = 2;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;

  energy_voice_activity_segmenter_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // register mirror, same reset values as the block
  // ---------------------------------------------------------------------
  logic                mir_stereo;
  logic [15:0]         mir_window_len;
  logic [ENERGY_W-1:0] mir_speech_energy;
  logic [ENERGY_W-1:0] mir_start_energy;
  logic [7:0]          mir_start_hits;
  logic [15:0]         mir_end_silence;
  logic [15:0]         mir_max_wait;

  // segmenter state as the predictor sees it
  logic                     vad_recording;
  logic [7:0]               vad_hits;
  logic [15:0]              vad_quiet;
  logic [16:0]              vad_waited;
  logic [15:0]              vad_window_pos;
  logic [ENERGY_W-1:0]      vad_energy;
  logic [1:0]               vad_decim_phase;
  logic signed [DSUM_W-1:0] vad_decim_sum;

  // result words still owed by the block, oldest first
  out_word_t queued_results[$];

  int  errors;
  int  words_sent;
  int  ev_count [4];
  bit  src_idle;         // sender inserts random gaps
  bit  snk_idle;         // receiver inserts random stalls
  bit  long_hold_req;    // ask the receiver for one long hold-off

  function automatic out_word_t result_word(ev_t ev, logic signed [SAMPLE_W-1:0] a);
    out_word_t r;
    r.event_res = ev;
    r.audio     = a;
    r.last      = 1'b0;
    return r;
  endfunction

  function automatic void clear_segment();
    vad_recording   = 1'b0;
    vad_hits        = '0;
    vad_quiet       = '0;
    vad_waited      = '0;
    vad_decim_phase = '0;
    vad_decim_sum   = '0;
  endfunction

  // one accepted audio word: update the predictor and queue what it causes
  function automatic void advance_segmenter(in_word_t w);
    out_word_t           caused[$];
    int                  pair_sum;
    int                  mono;
    int                  group;
    logic [ENERGY_W-1:0] sq;
    logic [ENERGY_W-1:0] closed;
    pair_sum = int'(w.left_sample) + int'(w.right_sample);
    // stereo average rounds toward minus infinity
    mono = mir_stereo ? (pair_sum >>> 1) : int'(w.left_sample);

    // decimator only runs while a segment is open
    if (vad_recording) begin
      vad_decim_sum   = vad_decim_sum + mono;
      vad_decim_phase = vad_decim_phase + 2'd1;
      if (vad_decim_phase == 2'd3) begin
        group = int'(vad_decim_sum);
        caused = {caused, result_word(EV_SAMPLE, SAMPLE_W'(group / 3))};
        vad_decim_phase = '0;
        vad_decim_sum   = '0;
      end
    end

    // window sum of squares, saturating
    sq = ENERGY_W'(mono * mono);
    if (vad_energy > E48_MAX - sq) begin
      vad_energy = E48_MAX;
    end else begin
      vad_energy = vad_energy + sq;
    end

    // a zero length acts as one, a shortened window closes right away
    if (vad_window_pos + 1 >= mir_window_len) begin
      closed         = vad_energy;
      vad_window_pos = '0;
      vad_energy     = '0;
      if (!vad_recording) begin
        vad_waited = vad_waited + 17'd1;
        if (vad_waited > mir_max_wait) begin
          clear_segment();
          caused = {caused, result_word(EV_TIMEOUT, '0)};
        end else if (closed > mir_speech_energy && closed >= mir_start_energy) begin
          if (vad_hits != 8'hFF) vad_hits = vad_hits + 8'd1;
          if (vad_hits >= mir_start_hits) begin
            vad_recording   = 1'b1;
            vad_quiet       = '0;
            vad_decim_phase = '0;
            vad_decim_sum   = '0;
            caused = {caused, result_word(EV_START, '0)};
          end
        end else begin
          vad_hits = '0;
        end
      end else begin
        if (closed < mir_speech_energy) begin
          if (vad_quiet != 16'hFFFF) vad_quiet = vad_quiet + 16'd1;
        end else begin
          vad_quiet = '0;
        end
        if (vad_quiet >= mir_end_silence) begin
          clear_segment();
          caused = {caused, result_word(EV_END, '0)};
        end
      end
    end else begin
      vad_window_pos = vad_window_pos + 16'd1;
    end

    if (caused.size() > 0) caused[caused.size()-1].last = 1'b1;
    queued_results = {queued_results, caused};
  endfunction

  // ---------------------------------------------------------------------
  // channel drivers
  // ---------------------------------------------------------------------

  // offer one word, optionally after a random gap, and wait for acceptance
  task automatic send_word(in_word_t w);
    int gap;
    @(negedge clk);
    if (src_idle && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    advance_segmenter(w);
  endtask

  // drop valid, wait for every owed result, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (queued_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write; only called with the block idle
  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_STEREO:     mir_stereo        = val[0];
      CFG_WINDOW_LEN: mir_window_len    = val[15:0];
      CFG_SPEECH_E:   mir_speech_energy = val[ENERGY_W-1:0];
      CFG_START_E:    mir_start_energy  = val[ENERGY_W-1:0];
      CFG_START_HITS: mir_start_hits    = val[7:0];
      CFG_END_SIL:    mir_end_silence   = val[15:0];
      CFG_MAX_WAIT:   mir_max_wait      = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(bit stereo, logic [15:0] wlen, logic [47:0] speech,
                            logic [47:0] smin, logic [7:0] hits,
                            logic [15:0] endsil, logic [15:0] maxwait);
    write_reg(CFG_STEREO, 48'(stereo));
    write_reg(CFG_WINDOW_LEN, 48'(wlen));
    write_reg(CFG_SPEECH_E, speech);
    write_reg(CFG_START_E, smin);
    write_reg(CFG_START_HITS, 48'(hits));
    write_reg(CFG_END_SIL, 48'(endsil));
    write_reg(CFG_MAX_WAIT, 48'(maxwait));
  endtask

  function automatic in_word_t pair(int l, int r);
    in_word_t w;
    w.left_sample  = SAMPLE_W'(l);
    w.right_sample = SAMPLE_W'(r);
    return w;
  endfunction

  // loud words keep both channels large and of one sign so the mono
  // magnitude stays high in either mode
  function automatic in_word_t make_frame(int kind);
    int  l;
    int  r;
    bit  neg;
    neg = $urandom_range(0, 1);
    case (kind)
      FRAME_LOUD: begin
        l = $urandom_range(24000, 32767);
        r = $urandom_range(24000, 32767);
        if (neg) begin
          l = -l;
          r = -r;
        end
      end
      FRAME_QUIET: begin
        l = $urandom_range(0, 1200);
        r = $urandom_range(0, 1200);
        if (neg) l = -l;
        if ($urandom_range(0, 1)) r = -r;
      end
      default: begin
        return in_word_t'($urandom);
      end
    endcase
    return pair(l, r);
  endfunction

  // ---------------------------------------------------------------------
  // receiver: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = LONG_HOLD_CYCLES - 1;
        out_ready     <= 1'b0;
      end else if (snk_idle && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 18);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // result checker, oldest expectation first
  always @(posedge clk) begin : result_check
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (queued_results.size() == 0) begin
        errors++;
        if (errors <= 100)
          $display({"%0t: unexpected result word: expected none, ",
                    "actual ev=%0d audio=%0d last=%0d"},
                   $time, out_data.event_res, out_data.audio, out_data.last);
      end else begin
        want = queued_results[0];
        queued_results.delete(0);
        if (out_data.event_res !== want.event_res || out_data.audio !== want.audio ||
            out_data.last !== want.last) begin
          errors++;
          if (errors <= 100)
            $display({"%0t: result mismatch: expected ev=%0d audio=%0d last=%0d, ",
                      "actual ev=%0d audio=%0d last=%0d"},
                     $time, want.event_res, want.audio, want.last,
                     out_data.event_res, out_data.audio, out_data.last);
        end
        ev_count[want.event_res]++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // full scale samples, stereo floor average, start, decimation with
  // truncation toward zero, end with a partial group dropped
  task automatic test_sample_extremes();
    set_config(1'b1, 16'd1, 48'h3FFF_FFFF, '0, 8'd1, 16'd2, 16'hFFFF);
    send_word(pair(32767, 32767));       // just under threshold
    send_word(pair(-32768, -32768));     // loud, starts
    repeat (3) send_word(pair(-32768, -32768));
    send_word(pair(32767, -32768));      // mono is -1
    send_word(pair(-1, 0));              // second quiet window ends
    settle();
    // mono mode: right channel ignored
    write_reg(CFG_STEREO, 48'd0);
    write_reg(CFG_END_SIL, 48'd4);
    send_word(pair(-32768, 32767));
    send_word(pair(5, -32768));
    send_word(pair(-7, 32767));
    send_word(pair(1, 0));               // group sum -1 gives zero
    send_word(pair(0, 0));
    settle();
  endtask

  // zero window length acts as one sample, thresholds at their maxima,
  // wait budget running out
  task automatic test_window_zero_timeout();
    set_config(1'b1, 16'd0, E48_MAX, E48_MAX, 8'd1, 16'd1, 16'd2);
    repeat (3) send_word(make_frame(FRAME_NOISE));
    settle();
    write_reg(CFG_MAX_WAIT, 48'd0);
    send_word(make_frame(FRAME_NOISE));
    settle();
  endtask

  // zero hit and silence counts, segment that closes before any sample
  task automatic test_zero_counts();
    set_config(1'b1, 16'd2, '0, '0, 8'd0, 16'd0, 16'd100);
    send_word(pair(100, 100));
    send_word(pair(0, 0));
    send_word(pair(0, 0));
    send_word(pair(0, 0));
    settle();
  endtask

  // longest window, then cut short mid-window; unmapped index on the way
  task automatic test_window_shrink();
    set_config(1'b0, 16'hFFFF, '0, '0, 8'd1, 16'd0, 16'd100);
    repeat (3) send_word(make_frame(FRAME_LOUD));
    settle();
    write_reg(CFG_UNUSED, 48'({$urandom, $urandom}));
    write_reg(CFG_WINDOW_LEN, 48'd2);
    repeat (3) send_word(make_frame(FRAME_LOUD));
    settle();
  endtask

  // receiver stops for a long stretch while words keep coming, so the
  // result queue fills and the input side has to stall
  task automatic test_backpressure();
    src_idle = 1'b0;
    set_config(1'b0, 16'd1, 48'd1 << 28, '0, 8'd0, 16'd1, 16'hFFFF);
    long_hold_req = 1'b1;
    repeat (48) send_word(make_frame($urandom_range(FRAME_LOUD, FRAME_QUIET)));
    settle();
    src_idle = 1'b1;
  endtask

  // the largest hit count: 255 loud windows before a start
  task automatic test_hit_run();
    set_config(1'b1, 16'd1, 48'd1 << 29, 48'd1 << 29, 8'd255, 16'd3, 16'hFFFF);
    repeat (260) send_word(make_frame(FRAME_LOUD));
    repeat (3) send_word(make_frame(FRAME_QUIET));
    settle();
  endtask

  // random settings, bursts of loud and quiet windows with some noise;
  // the last phase runs without idling on either side
  task automatic test_random_phases(int phases, int words_per_phase);
    logic [15:0]    wlen;
    int             weff;
    longint         per_word;
    logic [47:0]    speech;
    logic [47:0]    smin;
    logic [15:0]    endsil;
    logic [15:0]    maxwait;
    int             kind;
    int             span;
    int             start_count;
    for (int p = 0; p < phases; p++) begin
      if (p == phases - 1) begin
        src_idle = 1'b0;
        snk_idle = 1'b0;
      end
      case ($urandom_range(0, 9))
        0:       wlen = 16'd0;
        1, 2:    wlen = 16'($urandom_range(5, 12));
        default: wlen = 16'($urandom_range(1, 4));
      endcase
      weff     = (wlen == 0) ? 1 : int'(wlen);
      per_word = $urandom_range(1 << 27, 1 << 29);
      speech   = 48'(weff * per_word);
      case ($urandom_range(0, 3))
        0, 1:    smin = '0;
        2:       smin = speech;
        default: smin = speech + 48'(weff * (1 << 26));
      endcase
      endsil = ($urandom_range(0, 19) == 0) ? 16'hFFFF : 16'($urandom_range(0, 4));
      case ($urandom_range(0, 9))
        0:       maxwait = 16'd0;
        1:       maxwait = 16'hFFFF;
        default: maxwait = 16'($urandom_range(2, 30));
      endcase
      set_config($urandom_range(0, 1), wlen, speech, smin,
                 8'($urandom_range(0, 4)), endsil, maxwait);
      start_count = words_sent;
      while (words_sent - start_count < words_per_phase) begin
        kind = $urandom_range(0, 99);
        if (kind < 45) kind = FRAME_LOUD;
        else if (kind < 85) kind = FRAME_QUIET;
        else kind = FRAME_NOISE;
        span = $urandom_range(1, 6) * weff;
        repeat (span) send_word(make_frame(kind));
      end
      settle();
    end
  endtask

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    errors        = 0;
    words_sent    = 0;
    src_idle      = 1'b1;
    snk_idle      = 1'b1;
    long_hold_req = 1'b0;
    foreach (ev_count[i]) ev_count[i] = 0;
    mir_stereo        = 1'b1;
    mir_window_len    = 16'd1440;
    mir_speech_energy = 48'd1000000000;
    mir_start_energy  = 48'd1000000000;
    mir_start_hits    = 8'd3;
    mir_end_silence   = 16'd27;
    mir_max_wait      = 16'd333;
    clear_segment();
    vad_window_pos = '0;
    vad_energy     = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_sample_extremes();
    test_window_zero_timeout();
    test_zero_counts();
    test_window_shrink();
    test_backpressure();
    test_hit_run();
    test_random_phases(4, 60);

    settle();
    if (queued_results.size() != 0) errors++;

    $display("sent %0d audio words over directed cases, backpressure and random settings",
             words_sent);
    $display("checked %0d decimated samples, %0d starts, %0d segment ends, %0d timeouts",
             ev_count[EV_SAMPLE], ev_count[EV_START], ev_count[EV_END], ev_count[EV_TIMEOUT]);
    if (errors == 0) begin
      $display("energy_voice_activity_segmenter_core test passed");
    end else begin
      $display("energy_voice_activity_segmenter_core test failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("energy_voice_activity_segmenter_core test failed");
    $finish;
  end

endmodule
